// ===== hdl/afk_pkg.sv =====
// Shared types and constants of the feed knob filter.
// No dependencies; compile this file first.
package afk_pkg;

    localparam int FEED_W = 16;
    localparam int CHG_W  = 2;
    localparam int MODE_W = 2;
    localparam int REG_W  = 2;
    localparam int TENTH_W = 13;

    typedef logic [FEED_W-1:0]  t_feed;
    typedef logic [CHG_W-1:0]   t_chg;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [REG_W-1:0]   t_reg;
    typedef logic [TENTH_W-1:0] t_tenth;

    // Mode classes of the input word.
    localparam t_mode MODE_RATE  = 2'd1;
    localparam t_mode MODE_AXIAL = 2'd2;

    // Change codes of the result word.
    localparam t_chg CHG_NONE  = 2'd0;
    localparam t_chg CHG_FEED  = 2'd1;
    localparam t_chg CHG_AXIAL = 2'd2;

    // Configuration register indexes.
    localparam t_reg REG_FEED_TOP    = 2'd0;
    localparam t_reg REG_FEED_BOTTOM = 2'd1;
    localparam t_reg REG_MAX_AXIAL   = 2'd2;
    localparam t_reg REG_MIN_AXIAL   = 2'd3;

    // Reset values; the axial limits are kept in whole tenths.
    localparam t_feed  RST_FEED_TOP    = 16'd250;
    localparam t_feed  RST_FEED_BOTTOM = 16'd5;
    localparam t_tenth RST_MAX_AXIAL_T = 13'd400;
    localparam t_tenth RST_MIN_AXIAL_T = 13'd15;

    // Samples within this distance of the filtered value are ignored.
    localparam int DEADBAND = 4;

    // x / 10 for any 16-bit x equals (x * DIV10_MUL) >> DIV10_SHIFT.
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

endpackage

// ===== hdl/afk_if.sv =====
// Handshake channels of the feed knob filter: sample input, result output
// and register write port. Depends on afk_pkg.
interface afk_in_if import afk_pkg::*; #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    t_mode                  mode_class;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output mode_class, output sample, input ready);
    modport sink   (input valid, input mode_class, input sample, output ready);
endinterface

interface afk_out_if import afk_pkg::*; #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    t_feed                  feed_value;
    t_chg                   change_code;
    logic [SAMPLE_BITS-1:0] filtered;

    modport source (output valid, output feed_value, output change_code,
                    output filtered, input ready);
    modport sink   (input valid, input feed_value, input change_code,
                    input filtered, output ready);
endinterface

interface afk_cfg_if import afk_pkg::*;;
    logic  valid;
    logic  ready;
    t_reg  index;
    t_feed data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/adc_feed_knob_filter_core.sv =====
// Feed knob filter: deadband moving average over a sample ring and inverse
// mapping onto the feed ranges. Depends on afk_pkg and the channels in afk_if.
//
//  channel  direction  word contents                          handshake
//  i_in     in         mode_class, sample                     valid/ready
//  o_out    out        feed_value, change_code, filtered      valid/ready
//  i_cfg    in         index, data (register write)           valid/ready, ready always high
//
// One word is accepted per cycle while the stages ahead are free. Each result word
// passes the stage 1, stage 2 and output registers after its input word is accepted.
// The rate is set by the filter update around the ring memory (read ahead,
// written back in the accept cycle).
// Reset is synchronous and active low. Ring entries carry valid bits cleared
// by reset, so no clearing pass is needed. Stages advance independently, so
// input words keep flowing into empty stages while the output word waits.
module adc_feed_knob_filter_core import afk_pkg::*; #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    afk_in_if.sink     i_in,
    afk_out_if.source  o_out,
    afk_cfg_if.sink    i_cfg
);

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int SUM_W   = SAMPLE_BITS + IDX_W;
    localparam int SHIFT   = SUM_W + IDX_W;
    // Rounded-up reciprocal of WINDOW; exact floor division for every sum.
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];
    localparam int PROD_W  = FEED_W + 2 + SAMPLE_BITS;
    localparam int SPAN_W  = FEED_W + 2;

    typedef logic [SAMPLE_BITS-1:0] t_smp;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [SUM_W-1:0]       t_sum;

    // ------------------------------------------------------------------
    // Configuration registers. Axial limits are divided by ten on write.
    // ------------------------------------------------------------------
    t_feed  r_feed_top, r_feed_bottom;
    t_tenth r_max_ax_t, r_min_ax_t;
    logic [32:0] cfg_div10;

    assign i_cfg.ready = 1'b1;
    assign cfg_div10   = 33'(i_cfg.data) * 33'(DIV10_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_top    <= RST_FEED_TOP;
            r_feed_bottom <= RST_FEED_BOTTOM;
            r_max_ax_t    <= RST_MAX_AXIAL_T;
            r_min_ax_t    <= RST_MIN_AXIAL_T;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FEED_TOP:    r_feed_top    <= i_cfg.data;
                REG_FEED_BOTTOM: r_feed_bottom <= i_cfg.data;
                REG_MAX_AXIAL:   r_max_ax_t <= cfg_div10[DIV10_SHIFT +: TENTH_W];
                REG_MIN_AXIAL:   r_min_ax_t <= cfg_div10[DIV10_SHIFT +: TENTH_W];
                default:         r_feed_top    <= r_feed_top;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves when the next one is free.
    // ------------------------------------------------------------------
    logic r_s1_vld, r_s2_vld, r_o_vld;
    logic s3_free, s2_move, s2_free, s1_move, s1_free, accept;

    assign s3_free   = !r_o_vld || o_out.ready;
    assign s2_move   = r_s2_vld && s3_free;
    assign s2_free   = !r_s2_vld || s2_move;
    assign s1_move   = r_s1_vld && s2_free;
    assign s1_free   = !r_s1_vld || s1_move;
    assign i_in.ready = s1_free;
    assign accept    = i_in.valid && s1_free;

    // ------------------------------------------------------------------
    // Stage 1: filter update. The ring entry that the next update replaces
    // is always read ahead, so the accept cycle only does the writeback.
    // ------------------------------------------------------------------
    t_smp r_ring [WINDOW];
    logic r_ring_vld [WINDOW];
    t_smp r_rd_data;
    logic r_rd_vld;
    t_idx r_idx, n_idx, rd_addr;
    t_sum r_sum, n_sum;
    t_smp r_filt, n_filt;
    logic active, take;
    t_smp old_smp;
    logic [SUM_W+SUM_W:0] avg_prod;

    assign active  = (i_in.mode_class == MODE_RATE) || (i_in.mode_class == MODE_AXIAL);
    assign take    = accept && active &&
                     (({1'b0, i_in.sample} > ({1'b0, r_filt} + (SAMPLE_BITS+1)'(DEADBAND))) ||
                      (({1'b0, i_in.sample} + (SAMPLE_BITS+1)'(DEADBAND)) > {1'b0, r_filt}
                       ? 1'b0 : ({1'b0, i_in.sample} + (SAMPLE_BITS+1)'(DEADBAND))
                                != {1'b0, r_filt}));
    assign old_smp = r_rd_vld ? r_rd_data : '0;
    assign avg_prod = (SUM_W+SUM_W+1)'(n_sum) * (SUM_W+SUM_W+1)'(RECIP);

    always_comb begin
        n_idx  = r_idx;
        n_sum  = r_sum;
        n_filt = r_filt;
        if (take) begin
            n_idx  = (r_idx == t_idx'(WINDOW-1)) ? '0 : r_idx + t_idx'(1);
            n_sum  = r_sum - t_sum'(old_smp) + t_sum'(i_in.sample);
            n_filt = avg_prod[SHIFT +: SAMPLE_BITS];
        end
    end

    assign rd_addr = (n_idx == t_idx'(WINDOW-1)) ? '0 : n_idx + t_idx'(1);

    // Ring memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ring[n_idx] <= i_in.sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_ring_vld[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_filt   <= '0;
        end else begin
            if (take) begin
                r_ring_vld[n_idx] <= 1'b1;
            end
            r_rd_vld <= r_ring_vld[rd_addr];
            r_idx    <= n_idx;
            r_sum    <= n_sum;
            r_filt   <= n_filt;
        end
    end

    t_mode r_s1_mode;
    t_smp  r_s1_filt;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= i_in.mode_class;
            r_s1_filt <= n_filt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: span times filtered level for the selected range.
    // ------------------------------------------------------------------
    t_feed sel_hi, sel_lo;
    logic signed [SPAN_W-1:0] span;
    logic signed [PROD_W-1:0] n_s2_prod, r_s2_prod;
    t_mode r_s2_mode;
    t_smp  r_s2_filt;
    t_feed r_s2_hi;

    always_comb begin
        if (r_s1_mode == MODE_AXIAL) begin
            sel_hi = FEED_W'(r_max_ax_t);
            sel_lo = FEED_W'(r_min_ax_t);
        end else begin
            sel_hi = r_feed_top;
            sel_lo = r_feed_bottom;
        end
    end

    assign span      = $signed({2'b00, sel_hi}) - $signed({2'b00, sel_lo}) + SPAN_W'(1);
    assign n_s2_prod = PROD_W'(span) * PROD_W'($signed({1'b0, r_s1_filt}));

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_mode <= r_s1_mode;
            r_s2_filt <= r_s1_filt;
            r_s2_hi   <= sel_hi;
            r_s2_prod <= n_s2_prod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient toward zero, final value, change detection.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] quot;
    t_feed map_val, ax_val, n_o_feed;
    t_chg  n_o_code;
    t_feed r_stored_feed, r_stored_ax;
    t_feed r_o_feed;
    t_chg  r_o_code;
    t_smp  r_o_filt;

    assign quot    = (r_s2_prod + (r_s2_prod[PROD_W-1]
                                   ? PROD_W'((1 << SAMPLE_BITS) - 1) : PROD_W'(0)))
                     >>> SAMPLE_BITS;
    assign map_val = r_s2_hi - quot[FEED_W-1:0];
    assign ax_val  = (map_val << 3) + (map_val << 1);

    always_comb begin
        n_o_feed = '0;
        n_o_code = CHG_NONE;
        if (r_s2_mode == MODE_RATE) begin
            n_o_feed = map_val;
            if (map_val != r_stored_feed) begin
                n_o_code = CHG_FEED;
            end
        end else if (r_s2_mode == MODE_AXIAL) begin
            n_o_feed = ax_val;
            if (ax_val != r_stored_ax) begin
                n_o_code = CHG_AXIAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_feed <= '0;
            r_stored_ax   <= '0;
        end else if (s2_move) begin
            if (n_o_code == CHG_FEED) begin
                r_stored_feed <= n_o_feed;
            end
            if (n_o_code == CHG_AXIAL) begin
                r_stored_ax <= n_o_feed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_o_feed <= n_o_feed;
            r_o_code <= n_o_code;
            r_o_filt <= r_s2_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= accept;
            end
            if (s2_free) begin
                r_s2_vld <= s1_move;
            end
            if (s3_free) begin
                r_o_vld <= s2_move;
            end
        end
    end

    assign o_out.valid       = r_o_vld;
    assign o_out.feed_value  = r_o_feed;
    assign o_out.change_code = r_o_code;
    assign o_out.filtered    = r_o_filt;

endmodule

// ===== sim/knob_filter_checker.sv =====
// Checker of the feed knob filter: watches the sample, result and register channels,
// predicts every result word and compares it with what the block delivers.
// Depends on afk_pkg and the channel interfaces in afk_if.
`timescale 1ns / 100ps

module knob_filter_checker import afk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    afk_in_if    i_in,
    afk_out_if   i_out,
    afk_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int FULL_SCALE  = 1 << SAMPLE_BITS;
    localparam int TENTHS      = 10;

    typedef logic [SAMPLE_BITS-1:0] t_level;

    typedef struct packed {
        t_feed  feed_value;
        t_chg   change_code;
        t_level filtered;
    } t_knob_result;

    // Register copies, kept as written (the axial limits are divided at use).
    t_feed feed_top;
    t_feed feed_bottom;
    t_feed max_axial;
    t_feed min_axial;

    // Filter and feed state.
    t_level      ring [WINDOW];
    logic [15:0] ring_sum;
    logic [3:0]  ring_pos;
    t_level      knob_level;
    t_feed       feed_held;
    t_feed       axial_held;

    t_knob_result awaited_results [$];

    // Inverse mapping; the span is signed and its quotient truncates toward zero.
    function automatic t_feed inverse_map(int unsigned hi, int unsigned lo, t_level lvl);
        longint span;
        longint quot;
        longint val;
        span = longint'(hi) - longint'(lo) + 1;
        quot = span * longint'(lvl) / FULL_SCALE;
        val  = longint'(hi) - quot;
        return val[FEED_W-1:0];
    endfunction

    function automatic t_knob_result filter_and_map(t_mode mode, t_level raw);
        t_knob_result res;
        t_feed        mapped;
        int unsigned  scaled;
        res.feed_value  = '0;
        res.change_code = CHG_NONE;
        if (mode == MODE_RATE || mode == MODE_AXIAL) begin
            if (int'(raw) > int'(knob_level) + DEADBAND ||
                int'(raw) + DEADBAND < int'(knob_level)) begin
                // The 4-bit position wraps at the window size of 16.
                ring_pos       = ring_pos + 4'd1;
                ring_sum       = ring_sum - 16'(ring[ring_pos]) + 16'(raw);
                ring[ring_pos] = raw;
                knob_level     = t_level'(ring_sum / WINDOW);
            end
            if (mode == MODE_RATE) begin
                mapped = inverse_map(32'(feed_top), 32'(feed_bottom), knob_level);
                if (mapped != feed_held) begin
                    feed_held       = mapped;
                    res.change_code = CHG_FEED;
                end
            end else begin
                mapped = inverse_map(max_axial / TENTHS, min_axial / TENTHS, knob_level);
                scaled = mapped * TENTHS;
                mapped = scaled[FEED_W-1:0];
                if (mapped != axial_held) begin
                    axial_held      = mapped;
                    res.change_code = CHG_AXIAL;
                end
            end
            res.feed_value = mapped;
        end
        res.filtered = knob_level;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_knob_result want;
        if (!i_rst_n) begin
            feed_top    = RST_FEED_TOP;
            feed_bottom = RST_FEED_BOTTOM;
            max_axial   = 16'd4000;
            min_axial   = 16'd150;
            for (int k = 0; k < WINDOW; k++) ring[k] = '0;
            ring_sum   = '0;
            ring_pos   = '0;
            knob_level = '0;
            feed_held  = '0;
            axial_held = '0;
            awaited_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word arrived with no word outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out.feed_value !== want.feed_value) begin
                        $error("feed_value: expected %0d, actual %0d",
                               want.feed_value, i_out.feed_value);
                        o_fail_count++;
                    end
                    if (i_out.change_code !== want.change_code) begin
                        $error("change_code: expected %0d, actual %0d",
                               want.change_code, i_out.change_code);
                        o_fail_count++;
                    end
                    if (i_out.filtered !== want.filtered) begin
                        $error("filtered: expected %0d, actual %0d",
                               want.filtered, i_out.filtered);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_FEED_TOP:    feed_top    = i_cfg.data;
                    REG_FEED_BOTTOM: feed_bottom = i_cfg.data;
                    REG_MAX_AXIAL:   max_axial   = i_cfg.data;
                    REG_MIN_AXIAL:   min_axial   = i_cfg.data;
                    default:         ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                awaited_results.push_back(filter_and_map(i_in.mode_class, i_in.sample));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ===== sim/tb_adc_feed_knob_filter_core.sv =====
// Testbench top of the feed knob filter: clock, reset, sample and register stimulus,
// result back-pressure and the verdict. Depends on afk_pkg, afk_if, the block
// and the checker in knob_filter_checker.
`timescale 1ns / 100ps

module tb_adc_feed_knob_filter_core;
    import afk_pkg::*;

    localparam int SAMPLE_BITS    = 12;
    localparam int FULL_LEVEL     = (1 << SAMPLE_BITS) - 1;
    localparam int PHASE_ITEMS    = 125;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 120;
    localparam int FIRST_HOLD_AT  = 200;
    localparam int SECOND_HOLD_AT = 800;

    // Mode codes that the package leaves unnamed: the knob is unused, or the code is spare.
    localparam t_mode MODE_IDLE  = 2'd0;
    localparam t_mode MODE_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;

    int fail_count;
    int pending;
    int results_seen = 0;
    int cycle_count  = 0;
    logic [SAMPLE_BITS-1:0] last_level = '0;

    afk_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    afk_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();
    afk_cfg_if cfg_ch ();

    adc_feed_knob_filter_core #(
        .WINDOW      (16),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    knob_filter_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The run is cut off if it takes far longer than the slowest correct run would.
    initial begin
        while (cycle_count <= LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Track delivered result words. The last filtered value lets the sample
    // generator aim at the edges of the deadband.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen <= results_seen + 1;
            last_level   <= out_ch.filtered;
        end
    end

    // Result receiver. Its ready pattern rotates through always ready, coin flips,
    // a periodic stall and mostly stalled. Twice it holds off for a long stretch
    // so that the block fills up and stalls its input.
    initial begin
        int rx_cycle;
        bit first_hold_done;
        bit second_hold_done;
        rx_cycle         = 0;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;
        out_ch.ready     = 1'b0;
        do @(negedge i_clk); while (!i_rst_n);
        forever begin
            if ((!first_hold_done && results_seen >= FIRST_HOLD_AT) ||
                (!second_hold_done && results_seen >= SECOND_HOLD_AT)) begin
                if (!first_hold_done) first_hold_done = 1'b1;
                else second_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                case ((rx_cycle / 97) % 4)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= (rx_cycle % 4) != 3;
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
                rx_cycle++;
                @(negedge i_clk);
            end
        end
    end

    // Offer one sample word and wait until the block takes it. Valid stays high
    // afterwards, so back-to-back words need no idle cycle between them.
    task automatic send_word(t_mode mode, int sample);
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.mode_class <= mode;
        in_ch.sample     <= sample[SAMPLE_BITS-1:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every outstanding result word has come back.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg index, t_feed data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Registers are only written while the block is idle.
    task automatic program_limits(t_feed max_f, t_feed min_f, t_feed max_a, t_feed min_a);
        settle();
        write_reg(REG_FEED_TOP, max_f);
        write_reg(REG_FEED_BOTTOM, min_f);
        write_reg(REG_MAX_AXIAL, max_a);
        write_reg(REG_MIN_AXIAL, min_a);
    endtask

    // A random register value, small in a quarter of the cases.
    function automatic t_feed random_limit();
        if ($urandom_range(0, 3) == 0) return t_feed'($urandom_range(0, 300));
        return t_feed'($urandom_range(0, 65535));
    endfunction

    // Directed words under the reset limits: both inactive codes, the deadband
    // just inside and just outside on both sides, and the sample extremes.
    task automatic run_directed();
        int base;
        send_word(MODE_IDLE, FULL_LEVEL);
        send_word(MODE_SPARE, FULL_LEVEL);
        send_word(MODE_RATE, DEADBAND);
        send_word(MODE_RATE, DEADBAND + 1);
        send_word(MODE_AXIAL, 0);
        for (int k = 0; k < 8; k++) begin
            send_word(k[0] ? MODE_AXIAL : MODE_RATE, FULL_LEVEL);
        end
        settle();
        base = int'(last_level);
        send_word(MODE_RATE, base + DEADBAND);
        send_word(MODE_AXIAL, base - DEADBAND);
        send_word(MODE_RATE, base + DEADBAND + 1);
        settle();
        base = int'(last_level);
        send_word(MODE_AXIAL, base - DEADBAND - 1);
        send_word(MODE_IDLE, 0);
        send_word(MODE_SPARE, 0);
        send_word(MODE_RATE, 0);
        send_word(MODE_AXIAL, FULL_LEVEL);
        send_word(MODE_RATE, 'h800);
        send_word(MODE_AXIAL, 'h555);
        send_word(MODE_RATE, 'hAAA);
    endtask

    // Random words in bursts with random gaps. Most samples are uniform, some sit
    // around the deadband edges, some are extremes, and now and then a run of
    // equal extreme samples sweeps the whole ring. Only active words are counted.
    task automatic run_random(int count);
        int    active_left;
        int    burst;
        int    gap;
        int    run_left;
        int    run_value;
        int    pick;
        int    sample;
        t_mode mode;
        active_left = count;
        run_left    = 0;
        run_value   = 0;
        while (active_left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && active_left > 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) mode = MODE_RATE;
                else if (pick < 80) mode = MODE_AXIAL;
                else if (pick < 90) mode = MODE_IDLE;
                else mode = MODE_SPARE;

                pick = $urandom_range(0, 99);
                if (run_left > 0) begin
                    sample = run_value;
                    run_left--;
                end else if (pick < 4) begin
                    run_value = $urandom_range(0, 1) ? FULL_LEVEL : 0;
                    run_left  = $urandom_range(16, 20);
                    sample    = run_value;
                end else if (pick < 34) begin
                    sample = int'(last_level) + $urandom_range(0, 16) - 8;
                    if (sample < 0) sample = 0;
                    if (sample > FULL_LEVEL) sample = FULL_LEVEL;
                end else if (pick < 44) begin
                    sample = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                  : FULL_LEVEL - $urandom_range(0, 7);
                end else begin
                    sample = $urandom_range(0, FULL_LEVEL);
                end

                send_word(mode, sample);
                if (mode == MODE_RATE || mode == MODE_AXIAL) active_left--;
                burst--;
            end
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode_class = MODE_IDLE;
        in_ch.sample     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_FEED_TOP;
        cfg_ch.data      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Full ranges, then both ranges reversed to the extremes.
        program_limits(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        run_random(PHASE_ITEMS);
        program_limits(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        run_random(PHASE_ITEMS);

        // Equal limits give a span of one.
        program_limits(16'd1000, 16'd1000, 16'd2000, 16'd2000);
        run_random(PHASE_ITEMS);

        // Back to the reset limits.
        program_limits(RST_FEED_TOP, RST_FEED_BOTTOM, 16'd4000, 16'd150);
        run_random(PHASE_ITEMS);

        repeat (4) begin
            program_limits(random_limit(), random_limit(), random_limit(), random_limit());
            run_random(PHASE_ITEMS);
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/afk_pkg.sv
hdl/afk_if.sv
hdl/adc_feed_knob_filter_core.sv
sim/knob_filter_checker.sv
sim/tb_adc_feed_knob_filter_core.sv
